// ===== rtl/dq_voltage_circle_limiter_top_defines.svh =====
// ---------------------------------------------------------------------------
// dq voltage circle limiter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DQ_VOLTAGE_CIRCLE_LIMITER_TOP_DEFINES_SVH
`define DQ_VOLTAGE_CIRCLE_LIMITER_TOP_DEFINES_SVH

// same-cycle implication
`define DQVCL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQVCL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dqvcl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqvcl_pkg
// Types and constants of the dq voltage circle limiter.
// ---------------------------------------------------------------------------
package dqvcl_pkg;

  typedef logic signed [15:0] volt_t;   // signed Q8.8
  typedef logic [15:0]        uvolt_t;  // unsigned Q8.8
  typedef logic [15:0]        mod_t;    // unsigned Q1.15

  // 1/sqrt(3) in unsigned Q0.16
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam mod_t        MAX_MOD_RESET = 16'd31130;

endpackage

// ===== rtl/dqvcl_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqvcl_in_if
// Input channel: voltage command and bus voltage word.
// ---------------------------------------------------------------------------
interface dqvcl_in_if;
  import dqvcl_pkg::*;

  logic   valid;
  logic   ready;
  volt_t  vd_in;
  volt_t  vq_in;
  uvolt_t bus_voltage;

  modport source (output valid, vd_in, vq_in, bus_voltage, input ready);
  modport sink   (input valid, vd_in, vq_in, bus_voltage, output ready);
endinterface

// ===== rtl/dqvcl_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqvcl_out_if
// Output channel: limited voltage vector and overmodulation flag word.
// ---------------------------------------------------------------------------
interface dqvcl_out_if;
  import dqvcl_pkg::*;

  logic  valid;
  logic  ready;
  volt_t vd_out;
  volt_t vq_out;
  logic  overmodulated;

  modport source (output valid, vd_out, vq_out, overmodulated, input ready);
  modport sink   (input valid, vd_out, vq_out, overmodulated, output ready);
endinterface

// ===== rtl/dq_voltage_circle_limiter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dq_voltage_circle_limiter_top
// Clamps a dq voltage vector to the circle set by bus voltage and modulation.
// ---------------------------------------------------------------------------
// Usage:
//   in_i carries one word per command: vd_in, vq_in (signed Q8.8) and
//   bus_voltage (unsigned Q8.8); out_o returns one word per input with
//   vd_out, vq_out and overmodulated, in order. A word moves when valid and
//   ready are both high at a rising clock edge.
//   cfg_we_i/cfg_wdata_i write the modulation ceiling (Q1.15); write it only
//   while no word is in flight.
//   There are 20 register stages from the accepting edge to out_o.valid:
//   3 for limit and squared magnitude, 8 for the square root (2 root bits
//   per stage), 8 for the two parallel dividers (2 quotient bits per
//   stage), and the output register. One word per cycle is accepted
//   sustained while out_o.ready stays high.
//   Every stage has its own valid bit; a stage loads when it is empty or
//   its successor moves, so a stalled receiver freezes only the full part
//   of the pipe and empty stages upstream keep taking words.
//   Reset (rst_ni low) empties the pipe and sets the modulation ceiling to
//   31130.
// ---------------------------------------------------------------------------
`include "dq_voltage_circle_limiter_top_defines.svh"

module dq_voltage_circle_limiter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  dqvcl_in_if.sink          in_i,
  dqvcl_out_if.source       out_o,
  input  logic              cfg_we_i,
  input  dqvcl_pkg::mod_t   cfg_wdata_i
);
  import dqvcl_pkg::*;

  localparam int ST_SQ0 = 3;               // first square root stage
  localparam int SQ_N   = 8;
  localparam int ST_DV0 = ST_SQ0 + SQ_N;   // first divider stage
  localparam int DV_N   = 8;
  localparam int ST_OUT = ST_DV0 + DV_N;   // output register
  localparam int NST    = ST_OUT + 1;
  localparam int OV_N   = ST_OUT - ST_SQ0;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sqst_t;

  typedef struct packed {
    logic [16:0] r;
    logic [15:0] q;
    logic [15:0] nlo;
  } dvst_t;

  // one root bit
  function automatic sqst_t sq_iter(sqst_t a);
    sqst_t       b;
    logic [18:0] acc;
    logic [17:0] trial;
    acc   = {a.rem, a.rad[31:30]};
    trial = {a.root, 2'b01};
    b.rad = {a.rad[29:0], 2'b00};
    if (acc >= 19'(trial)) begin
      b.rem  = 17'(acc - 19'(trial));
      b.root = {a.root[14:0], 1'b1};
    end else begin
      b.rem  = acc[16:0];
      b.root = {a.root[14:0], 1'b0};
    end
    return b;
  endfunction

  // one quotient bit
  function automatic dvst_t dv_iter(dvst_t a, logic [15:0] mag);
    dvst_t       b;
    logic [17:0] acc;
    acc   = {a.r, a.nlo[15]};
    b.nlo = {a.nlo[14:0], 1'b0};
    if (acc >= 18'(mag)) begin
      b.r = 17'(acc - 18'(mag));
      b.q = {a.q[14:0], 1'b1};
    end else begin
      b.r = acc[16:0];
      b.q = {a.q[14:0], 1'b0};
    end
    return b;
  endfunction

  function automatic logic [15:0] abs16(volt_t v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // ---------------- configuration
  mod_t mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MAX_MOD_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage control
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = out_o.ready;

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign rdy[k] = !v_q[k] || rdy[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // ---------------- vector carried to the output
  volt_t vd_q [ST_OUT];
  volt_t vq_q [ST_OUT];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      vd_q[0] <= in_i.vd_in;
      vq_q[0] <= in_i.vq_in;
    end
  end

  for (genvar k = 1; k < ST_OUT; k++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        vd_q[k] <= vd_q[k-1];
        vq_q[k] <= vq_q[k-1];
      end
    end
  end

  // ---------------- stages 0..2: limit, squares, limit squared
  logic signed [31:0] sqd_full, sqq_full;
  logic [31:0] busk_q;
  logic [30:0] sqd_q, sqq_q;
  logic [47:0] lim_full;
  logic [16:0] lim1_q, lim2_q;
  logic [31:0] s1_q, s2_q;
  logic [33:0] limsq2_q;

  assign sqd_full = in_i.vd_in * in_i.vd_in;
  assign sqq_full = in_i.vq_in * in_i.vq_in;
  assign lim_full = 48'(busk_q) * 48'(mod_q);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      busk_q <= 32'(in_i.bus_voltage) * 32'(INV_SQRT3_Q16);
      sqd_q  <= sqd_full[30:0];
      sqq_q  <= sqq_full[30:0];
    end
    if (rdy[1]) begin
      lim1_q <= lim_full[47:31];
      s1_q   <= 32'(sqd_q) + 32'(sqq_q);
    end
    if (rdy[2]) begin
      lim2_q   <= lim1_q;
      s2_q     <= s1_q;
      limsq2_q <= 34'(lim1_q) * 34'(lim1_q);
    end
  end

  // ---------------- stages 3..10: compare, numerators, square root
  logic        ov_q [OV_N];
  logic [32:0] nd_q [SQ_N];
  logic [32:0] nq_q [SQ_N];
  sqst_t       sq_q [SQ_N];
  sqst_t       sq_init;

  assign sq_init = '{rem: 17'd0, root: 16'd0, rad: s2_q};

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SQ0]) begin
      ov_q[0] <= 34'(s2_q) > limsq2_q;
      nd_q[0] <= 33'(abs16(vd_q[ST_SQ0-1])) * 33'(lim2_q);
      nq_q[0] <= 33'(abs16(vq_q[ST_SQ0-1])) * 33'(lim2_q);
      sq_q[0] <= sq_iter(sq_iter(sq_init));
    end
  end

  for (genvar i = 1; i < SQ_N; i++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (rdy[ST_SQ0+i]) begin
        nd_q[i] <= nd_q[i-1];
        nq_q[i] <= nq_q[i-1];
        sq_q[i] <= sq_iter(sq_iter(sq_q[i-1]));
      end
    end
  end

  for (genvar k = 1; k < OV_N; k++) begin : g_ov
    always_ff @(posedge clk_i) begin
      if (rdy[ST_SQ0+k]) begin
        ov_q[k] <= ov_q[k-1];
      end
    end
  end

  // ---------------- stages 11..18: |v| * L / M for both axes
  logic [15:0] mag_eff;
  logic [15:0] mag_q [DV_N];
  dvst_t       dvd_q [DV_N];
  dvst_t       dvq_q [DV_N];
  dvst_t       dvd_init, dvq_init;

  // a zero root only comes with a zero vector, which never gets scaled
  assign mag_eff  = (sq_q[SQ_N-1].root == 16'd0) ? 16'd1 : sq_q[SQ_N-1].root;
  assign dvd_init = '{r: nd_q[SQ_N-1][32:16], q: 16'd0, nlo: nd_q[SQ_N-1][15:0]};
  assign dvq_init = '{r: nq_q[SQ_N-1][32:16], q: 16'd0, nlo: nq_q[SQ_N-1][15:0]};

  always_ff @(posedge clk_i) begin
    if (rdy[ST_DV0]) begin
      mag_q[0] <= mag_eff;
      dvd_q[0] <= dv_iter(dv_iter(dvd_init, mag_eff), mag_eff);
      dvq_q[0] <= dv_iter(dv_iter(dvq_init, mag_eff), mag_eff);
    end
  end

  for (genvar i = 1; i < DV_N; i++) begin : g_dv
    always_ff @(posedge clk_i) begin
      if (rdy[ST_DV0+i]) begin
        mag_q[i] <= mag_q[i-1];
        dvd_q[i] <= dv_iter(dv_iter(dvd_q[i-1], mag_q[i-1]), mag_q[i-1]);
        dvq_q[i] <= dv_iter(dv_iter(dvq_q[i-1], mag_q[i-1]), mag_q[i-1]);
      end
    end
  end

  // ---------------- stage 19: output register
  volt_t vd_last, vq_last;
  volt_t od_d, oq_d;
  logic  ov_last;
  volt_t od_q, oq_q;
  logic  ovm_q;
  logic [15:0] qd_last, qq_last;

  assign vd_last = vd_q[ST_OUT-1];
  assign vq_last = vq_q[ST_OUT-1];
  assign ov_last = ov_q[OV_N-1];
  assign qd_last = dvd_q[DV_N-1].q;
  assign qq_last = dvq_q[DV_N-1].q;

  always_comb begin
    od_d = vd_last;
    oq_d = vq_last;
    if (ov_last) begin
      od_d = vd_last[15] ? volt_t'(~qd_last + 16'd1) : volt_t'(qd_last);
      oq_d = vq_last[15] ? volt_t'(~qq_last + 16'd1) : volt_t'(qq_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      od_q  <= od_d;
      oq_q  <= oq_d;
      ovm_q <= ov_last;
    end
  end

  assign out_o.valid         = v_q[ST_OUT];
  assign out_o.vd_out        = od_q;
  assign out_o.vq_out        = oq_q;
  assign out_o.overmodulated = ovm_q;

  // ---------------- assertions
  logic chk_div_ok;
  assign chk_div_ok = (nd_q[SQ_N-1][32:16] < 17'(mag_eff)) &&
                      (nq_q[SQ_N-1][32:16] < 17'(mag_eff));

  `DQVCL_ASSERT_IMP(a_root_nonzero, v_q[ST_DV0-1] && ov_q[ST_DV0-1-ST_SQ0], sq_q[SQ_N-1].root != 16'd0, "overmodulated word with zero magnitude")
  `DQVCL_ASSERT_IMP(a_div_bound, v_q[ST_DV0-1] && ov_q[ST_DV0-1-ST_SQ0], chk_div_ok, "divider quotient would exceed 16 bits")
  `DQVCL_ASSERT_IMP(a_quo_bound, v_q[ST_OUT-1] && ov_last, (qd_last <= abs16(vd_last)) && (qq_last <= abs16(vq_last)), "scaled component larger than command")
  `DQVCL_ASSERT_NXT(a_stall_hold, v_q[ST_OUT-1] && !rdy[ST_OUT-1], v_q[ST_OUT-1] && $stable(qd_last) && $stable(ov_last), "stalled stage lost its word")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the dq voltage circle limiter. A queue-fed driver
// offers voltage command words and a clocked monitor predicts every limited
// vector at input acceptance and checks each output word in order, across
// several modulation settings and sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module tb;
  import dqvcl_pkg::*;

  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int STALL_LIMIT = 3000;   // cycles with no word moving
  localparam int TAIL_CYCLES = 40;     // pipe is 20 deep

  typedef struct {
    volt_t  vd;
    volt_t  vq;
    uvolt_t bus;
  } volt_cmd_t;

  typedef struct {
    volt_t vd;
    volt_t vq;
    logic  ovm;
  } limited_vec_t;

  logic clk_i = 1'b0;
  logic rst_n;
  logic cfg_we;
  mod_t cfg_wdata;

  dqvcl_in_if  in_bus ();
  dqvcl_out_if out_bus ();

  dq_voltage_circle_limiter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  volt_cmd_t    cmd_q[$];
  limited_vec_t limited_q[$];
  mod_t         mod_shadow;    // register mirror, tracked at the write edge
  mod_t         cur_mod;       // setting used to shape stimulus
  logic         in_fire_q;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_req = 0;
  int           hold_ack = 0;
  int           hold_left = 0;
  int           n_queued = 0;
  int           n_accepted = 0;
  int           n_checked = 0;
  int           n_over = 0;
  int           n_errors = 0;
  int           n_settings = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned circle_limit(input uvolt_t bus, input mod_t mmod);
    return (64'(bus) * 64'(INV_SQRT3_Q16) * 64'(mmod)) >> 31;
  endfunction

  function automatic limited_vec_t limit_vector(input volt_t vd, input volt_t vq,
                                                input uvolt_t bus, input mod_t mmod);
    longint unsigned lim, sq, mag, ad, aq, qd, qq;
    int              sd, sq_q;
    limited_vec_t    r;
    sd   = vd;
    sq_q = vq;
    ad   = 64'((sd < 0) ? -sd : sd);
    aq   = 64'((sq_q < 0) ? -sq_q : sq_q);
    lim  = circle_limit(bus, mmod);
    sq   = ad * ad + aq * aq;
    r.vd  = vd;
    r.vq  = vq;
    r.ovm = 1'b0;
    if (sq > lim * lim) begin
      mag = root_floor(sq);
      if (mag == 0) mag = 1;
      qd = (ad * lim) / mag;
      qq = (aq * lim) / mag;
      r.vd  = volt_t'((sd < 0) ? -int'(qd) : int'(qd));
      r.vq  = volt_t'((sq_q < 0) ? -int'(qq) : int'(qq));
      r.ovm = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (n_errors < 40) $display("ERROR @%0t: %s", $time, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // driver and receiver, both change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : cmd_driver
    volt_cmd_t c;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire_q) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        c = cmd_q.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.vd_in       <= c.vd;
        in_bus.vq_in       <= c.vq;
        in_bus.bus_voltage <= c.bus;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : hold_counter
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin : out_receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= (hold_left == 0) && (hold_ack == hold_req) &&
                       ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input words, checks output words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : word_monitor
    limited_vec_t got, want;
    if (!rst_n) begin
      mod_shadow <= MAX_MOD_RESET;
      in_fire_q  <= 1'b0;
    end else begin
      in_fire_q <= in_bus.valid && in_bus.ready;
      if (cfg_we) mod_shadow <= cfg_wdata;
      if (in_bus.valid && in_bus.ready) begin
        limited_q.push_back(limit_vector(in_bus.vd_in, in_bus.vq_in,
                                         in_bus.bus_voltage, mod_shadow));
        n_accepted++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.vd  = out_bus.vd_out;
        got.vq  = out_bus.vq_out;
        got.ovm = out_bus.overmodulated;
        n_checked++;
        if (got.ovm === 1'b1) n_over++;
        if (limited_q.size() == 0) begin
          flag_mismatch($sformatf("output word %0d with nothing expected", n_checked));
        end else begin
          want = limited_q.pop_front();
          if (got.vd !== want.vd)
            flag_mismatch($sformatf("word %0d vd_out %0d, expected %0d",
                                    n_checked, got.vd, want.vd));
          if (got.vq !== want.vq)
            flag_mismatch($sformatf("word %0d vq_out %0d, expected %0d",
                                    n_checked, got.vq, want.vq));
          if (got.ovm !== want.ovm)
            flag_mismatch($sformatf("word %0d overmodulated %b, expected %b",
                                    n_checked, got.ovm, want.ovm));
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stuck = 0;
      else stuck++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic int extreme_volt();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic volt_cmd_t random_cmd();
    volt_cmd_t       c;
    int unsigned     pick;
    longint unsigned lim;
    int              lc, t;
    pick = $urandom_range(99);
    c.vd  = volt_t'($urandom);
    c.vq  = volt_t'($urandom);
    c.bus = uvolt_t'($urandom);
    if (pick < 40) begin
      // vectors right on the circle, a few LSBs either side
      if ($urandom_range(3) != 0) c.bus = uvolt_t'($urandom_range(8191));
      lim = circle_limit(c.bus, cur_mod);
      lc  = (lim > 32767) ? 32767 : int'(lim);
      t   = int'($urandom_range(2 * lc)) - lc;
      c.vd = volt_t'(t);
      t = int'(root_floor(64'(lc) * 64'(lc) - 64'(t * t))) +
          int'($urandom_range(4)) - 2;
      if (t > 32767) t = 32767;
      if ($urandom_range(1)) t = -t;
      c.vq = volt_t'(t);
      if ($urandom_range(1)) begin
        c.vd = c.vq;
        c.vq = volt_t'(-int'(c.vd) + int'($urandom_range(2)) - 1);
        c.vq = volt_t'(c.vq == 16'sh8000 ? 0 : int'(c.vq));
        c.vq = volt_t'(t == 0 ? 0 : int'(c.vd));
        c.vd = volt_t'(int'($urandom_range(2 * lc)) - lc);
      end
    end else if (pick < 65) begin
      // full-range fields as already drawn
    end else if (pick < 80) begin
      c.vd  = volt_t'(int'($urandom_range(510)) - 255);
      c.vq  = volt_t'(int'($urandom_range(510)) - 255);
      c.bus = uvolt_t'($urandom_range(1023));
    end else if (pick < 90) begin
      c.vd = volt_t'(extreme_volt());
      c.vq = volt_t'(extreme_volt());
      case ($urandom_range(3))
        0:       c.bus = '0;
        1:       c.bus = 16'd1;
        2:       c.bus = 16'hFFFF;
        default: ;
      endcase
    end else if (pick < 95) begin
      c.vd = '0;
      c.vq = '0;
    end else begin
      c.bus = '0;
    end
    return c;
  endfunction

  task automatic push_cmd(input int vd, input int vq, input int bus);
    volt_cmd_t c;
    c.vd  = volt_t'(vd);
    c.vq  = volt_t'(vq);
    c.bus = uvolt_t'(bus);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || limited_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input bit wr, input mod_t mval, input int tx_pct,
                           input int rx_pct, input int n, input bit squeeze);
    volt_cmd_t c;
    if (wr) begin
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_wdata <= mval;
      @(negedge clk_i);
      cfg_we  <= 1'b0;
      cur_mod  = mval;
    end
    n_settings++;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      c = random_cmd();
      push_cmd(c.vd, c.vq, c.bus);
    end
    // receiver holds off while the sender keeps offering
    if (squeeze) hold_req++;
    wait_drained();
  endtask

  initial begin : stimulus
    int lim_at;
    in_bus.valid       = 1'b0;
    in_bus.vd_in       = '0;
    in_bus.vq_in       = '0;
    in_bus.bus_voltage = '0;
    out_bus.ready      = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cur_mod            = MAX_MOD_RESET;
    rst_n              = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // directed words at the reset modulation
    lim_at = int'(circle_limit(16'd4096, MAX_MOD_RESET));
    push_cmd(0, 0, 0);                 // zero vector, zero limit
    push_cmd(0, 0, 65535);
    push_cmd(1, 0, 0);                 // zero limit, nonzero vector
    push_cmd(0, -1, 0);
    push_cmd(-32768, -32768, 0);
    push_cmd(-32768, -32768, 65535);
    push_cmd(32767, 32767, 65535);
    push_cmd(32767, -32768, 1);
    push_cmd(-32768, 32767, 40000);
    push_cmd(lim_at, 0, 4096);         // exactly on the circle
    push_cmd(lim_at + 1, 0, 4096);     // one LSB outside
    push_cmd(0, -lim_at, 4096);
    push_cmd(0, -lim_at - 1, 4096);
    push_cmd(-1, -1, 1);
    push_cmd(255, -255, 256);
    push_cmd(-3000, 4000, 8000);
    push_cmd(16'h5555, 16'hAAAA, 16'hAAAA);
    push_cmd(16'hAAAA, 16'h5555, 16'h5555);

    run_phase(1'b0, MAX_MOD_RESET, 15, 56, 240, 1'b1);
    run_phase(1'b1, 16'd0,         15, 56, 100, 1'b0);
    run_phase(1'b1, 16'hFFFF,      56, 15, 250, 1'b1);
    run_phase(1'b1, 16'd32768,     56, 15, 250, 1'b0);
    run_phase(1'b1, 16'd1,          0,  0, 100, 1'b0);
    run_phase(1'b1, mod_t'($urandom_range(65535)), 0, 0, 300, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (limited_q.size() != 0)
      flag_mismatch($sformatf("%0d expected words never came out", limited_q.size()));

    $display("Sent %0d command words and checked %0d limited vectors (%0d overmodulated)",
             n_accepted, n_checked, n_over);
    $display("over %0d modulation settings incl. zero, 1.0, one LSB and the 16-bit max.",
             n_settings);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dqvcl_pkg.sv
rtl/dqvcl_in_if.sv
rtl/dqvcl_out_if.sv
rtl/dq_voltage_circle_limiter_top.sv
tb/sv/tb.sv
